>>> rtl/serial_frame_receiver_crc8_macros.svh
// ----------------------------------------------------------------------------
// Serial frame receiver assertion macros
// Immediate-implication and next-cycle-implication checks on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_CRC8_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_CRC8_MACROS_SVH

// ante holds -> cons holds in the same cycle
`define SFR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante holds -> cons holds in the next cycle
`define SFR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame receiver package
// Frame constants, result types and the bytewise CRC-8 update.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	localparam logic [7:0]  HdrFirst        = 8'hAA;
	localparam logic [7:0]  HdrSecond       = 8'hCC;
	localparam logic [7:0]  CrcPoly         = 8'h07;
	localparam logic [7:0]  CharCr          = 8'h0D;
	localparam logic [7:0]  CharLf          = 8'h0A;
	localparam logic [4:0]  PosHunt         = 5'd0;
	localparam logic [4:0]  PosHdrSecond    = 5'd1;
	localparam logic [4:0]  PosLenLow       = 5'd2;
	localparam logic [4:0]  PosLenHigh      = 5'd3;
	localparam logic [4:0]  PosCrcStart     = 5'd4;
	localparam logic [4:0]  PosCommand      = 5'd6;
	localparam logic [4:0]  PosType         = 5'd7;
	localparam logic [4:0]  PayloadStart    = 5'd8;
	localparam logic [4:0]  PayloadTopPos   = 5'd16;
	localparam logic [4:0]  MinTermPosition = 5'd11;
	localparam logic [4:0]  LastPosition    = 5'd30;
	localparam logic [15:0] MinLength       = 16'd8;
	localparam logic [15:0] BufferBytes     = 16'd32;
	localparam logic [15:0] CrcTail         = 16'd4;
	localparam logic [15:0] CheckTail       = 16'd3;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_OVERFLOW   = 2'd1,
		STATUS_BAD_LENGTH = 2'd2,
		STATUS_BAD_CRC    = 2'd3
	} status_t;

	typedef struct packed {
		status_t     frame_status;
		logic [7:0]  frame_command;
		logic [7:0]  frame_type;
		logic [15:0] length_value;
		logic [63:0] payload_low;
		logic [7:0]  payload_top;
	} result_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = {c[6:0], 1'b0} ^ (c[7] ? CrcPoly : 8'h00);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// Serial frame receiver channels
// Valid/ready channels for received bytes and frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_frame_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_status;
	logic [7:0]  frame_command;
	logic [7:0]  frame_type;
	logic [15:0] length_value;
	logic [63:0] payload_low;
	logic [7:0]  payload_top;

	modport source (
		output valid, output frame_status, output frame_command, output frame_type,
		output length_value, output payload_low, output payload_top, input ready
	);
	modport sink (
		input valid, input frame_status, input frame_command, input frame_type,
		input length_value, input payload_low, input payload_top, output ready
	);
endinterface

`default_nettype wire

>>> rtl/serial_frame_receiver_crc8.sv
// ----------------------------------------------------------------------------
// Serial frame receiver with CRC-8 check
// Assembles 0xAA 0xCC framed packets from a byte stream and reports status.
// ----------------------------------------------------------------------------
// Takes one byte per clock on rx while rx.ready is high. A byte is registered
// on entry and processed in the following cycle (header hunt, length/command/
// type/payload capture, bytewise CRC-8 poly 0x07). The frame result goes to
// the output result register, so frame.valid follows the ending byte through
// the input register and the result register. rx.ready drops only while a
// finished result is held and a new result is due with frame.ready low.
// Bytes that produce no result never cause a stall.
`default_nettype none

module serial_frame_receiver_crc8 (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sfr_rx_if.sink      rx,
	sfr_frame_if.source frame
);

	logic             slot_free;
	logic             res_valid;
	sfr_pkg::result_t res;

	sfr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res)
	);

	sfr_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free),
		.frame     (frame)
	);

endmodule

`default_nettype wire

>>> rtl/sfr_parse.sv
// ----------------------------------------------------------------------------
// Serial frame parser
// Input register, frame state and single-pass byte processing with CRC-8.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_frame_receiver_crc8_macros.svh"

module sfr_parse (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sfr_rx_if.sink          rx,
	input  wire logic       slot_free,
	output logic            res_valid,
	output sfr_pkg::result_t res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic [4:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] len_q;
	logic [7:0]  cmd_q;
	logic [7:0]  type_q;
	logic [63:0] pay_q;
	logic [7:0]  top_q;
	logic [7:0]  chk_q;
	logic [7:0]  prev_q;

	logic [4:0]  pos_d;
	logic [7:0]  crc_d;
	logic [15:0] len_d;
	logic [7:0]  cmd_d;
	logic [7:0]  type_d;
	logic [63:0] pay_d;
	logic [7:0]  top_d;
	logic [7:0]  chk_d;
	logic [7:0]  prev_d;

	logic        emit;
	logic        advance;
	sfr_pkg::result_t res_d;

	always_comb begin
		logic [15:0] pos16;
		logic        term;
		pos16  = {11'd0, pos_q};
		term   = 1'b0;
		pos_d  = pos_q;
		crc_d  = crc_q;
		len_d  = len_q;
		cmd_d  = cmd_q;
		type_d = type_q;
		pay_d  = pay_q;
		top_d  = top_q;
		chk_d  = chk_q;
		prev_d = prev_q;
		emit   = 1'b0;
		res_d  = '0;

		if (pos_q == sfr_pkg::PosHunt) begin
			if (byte_s1 == sfr_pkg::HdrFirst) begin
				crc_d  = '0;
				len_d  = '0;
				cmd_d  = '0;
				type_d = '0;
				pay_d  = '0;
				top_d  = '0;
				chk_d  = '0;
				prev_d = byte_s1;
				pos_d  = sfr_pkg::PosHdrSecond;
			end
		end else if (pos_q == sfr_pkg::PosHdrSecond) begin
			if (byte_s1 != sfr_pkg::HdrSecond) begin
				pos_d = sfr_pkg::PosHunt;
			end else begin
				prev_d = byte_s1;
				pos_d  = sfr_pkg::PosLenLow;
			end
		end else begin
			if (pos_q == sfr_pkg::PosLenLow) begin
				len_d = {len_q[15:8], byte_s1};
			end else if (pos_q == sfr_pkg::PosLenHigh) begin
				len_d = {byte_s1, len_q[7:0]};
			end else if (pos_q == sfr_pkg::PosCommand) begin
				cmd_d = byte_s1;
			end else if (pos_q == sfr_pkg::PosType) begin
				type_d = byte_s1;
			end else if (pos_q >= sfr_pkg::PayloadStart && pos_q < sfr_pkg::PayloadTopPos) begin
				pay_d[pos_q[2:0]*8 +: 8] = byte_s1;
			end else if (pos_q == sfr_pkg::PayloadTopPos) begin
				top_d = byte_s1;
			end

			if (pos_q >= sfr_pkg::PosCrcStart && (pos16 + sfr_pkg::CrcTail) <= len_d) begin
				crc_d = sfr_pkg::crc8_update(crc_q, byte_s1);
			end
			if ((pos16 + sfr_pkg::CheckTail) == len_d) begin
				chk_d = byte_s1;
			end

			term = (byte_s1 == sfr_pkg::CharCr) && (pos_q >= sfr_pkg::MinTermPosition)
				&& (prev_q == sfr_pkg::CharLf);

			if (term) begin
				emit = 1'b1;
				pos_d = sfr_pkg::PosHunt;
				if (len_d < sfr_pkg::MinLength || len_d > sfr_pkg::BufferBytes
					|| len_d > (pos16 + 16'd1)) begin
					res_d.frame_status = sfr_pkg::STATUS_BAD_LENGTH;
				end else if (crc_d != chk_d) begin
					res_d.frame_status = sfr_pkg::STATUS_BAD_CRC;
				end else begin
					res_d.frame_status = sfr_pkg::STATUS_OK;
				end
				res_d.frame_command = cmd_d;
				res_d.frame_type    = type_d;
				res_d.length_value  = len_d;
				for (int i = 0; i < 8; i++) begin
					if ({11'd0, sfr_pkg::PayloadStart} + 16'(i) < len_d) begin
						res_d.payload_low[i*8 +: 8] = pay_d[i*8 +: 8];
					end
				end
				if ({11'd0, sfr_pkg::PayloadTopPos} < len_d) begin
					res_d.payload_top = top_d;
				end
			end else begin
				prev_d = byte_s1;
				if (pos_q == sfr_pkg::LastPosition) begin
					emit = 1'b1;
					res_d.frame_status = sfr_pkg::STATUS_OVERFLOW;
					pos_d = sfr_pkg::PosHunt;
				end else begin
					pos_d = pos_q + 5'd1;
				end
			end
		end
	end

	assign advance   = valid_s1 && (!emit || slot_free);
	assign rx.ready  = !valid_s1 || advance;
	assign res_valid = advance && emit;
	assign res       = res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= sfr_pkg::PosHunt;
			crc_q  <= '0;
			len_q  <= '0;
			cmd_q  <= '0;
			type_q <= '0;
			pay_q  <= '0;
			top_q  <= '0;
			chk_q  <= '0;
			prev_q <= '0;
		end else if (advance) begin
			pos_q  <= pos_d;
			crc_q  <= crc_d;
			len_q  <= len_d;
			cmd_q  <= cmd_d;
			type_q <= type_d;
			pay_q  <= pay_d;
			top_q  <= top_d;
			chk_q  <= chk_d;
			prev_q <= prev_d;
		end
	end

	`SFR_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= sfr_pkg::LastPosition, "byte position past last")
	`SFR_ASSERT_NXT(a_hunt_after_result, res_valid, pos_q == sfr_pkg::PosHunt, "no resync after result")
	`SFR_ASSERT_IMP(a_hdr_prev, pos_q == sfr_pkg::PosHdrSecond, prev_q == sfr_pkg::HdrFirst,
		"second header slot without first header byte")

endmodule

`default_nettype wire

>>> rtl/sfr_outreg.sv
// ----------------------------------------------------------------------------
// Serial frame result register
// Holds one frame result until the sink takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_outreg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_valid,
	input  wire sfr_pkg::result_t res,
	output logic                  slot_free,
	sfr_frame_if.source           frame
);

	logic             full_q;
	sfr_pkg::result_t res_q;

	assign slot_free = !full_q || frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (res_valid) begin
			full_q <= 1'b1;
		end else if (frame.ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign frame.valid         = full_q;
	assign frame.frame_status  = res_q.frame_status;
	assign frame.frame_command = res_q.frame_command;
	assign frame.frame_type    = res_q.frame_type;
	assign frame.length_value  = res_q.length_value;
	assign frame.payload_low   = res_q.payload_low;
	assign frame.payload_top   = res_q.payload_top;

endmodule

`default_nettype wire
